FILE: hdl/tlca_pkg.sv
// Shared types, constants and helpers for the lowest-common-ancestor block.
// Used by tlca_front, tlca_back and tree_lowest_common_ancestor_top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlca_pkg;

  // Tree size and lifting levels.
  localparam int NODES       = 1024;
  localparam int LOG         = 10;
  localparam int NODE_W      = 10;
  localparam int DEPTH_W     = 11;
  localparam int LVL_W       = $clog2(LOG + 1);
  localparam int ANC_ENTRIES = NODES * LOG;
  localparam int ANC_AW      = $clog2(ANC_ENTRIES);
  localparam int NODE_AW     = $clog2(NODES);

  // Stream widths.
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;

  // Command codes carried on in_tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;

  localparam depth_t DEPTH_MAX = '1;

  // One classified command as it travels from front to back.
  // For an insert, node_a is the new node and node_b its parent.
  // For a query, node_a and node_b are the two queried nodes.
  typedef struct packed {
    logic  is_query;
    node_t node_a;
    node_t node_b;
  } op_t;

  // Address of one level of one node in the ancestor memory.
  function automatic anc_addr_t anc_addr(input node_t node, input lvl_t lvl);
    anc_addr = ANC_AW'(ANC_AW'(node) * ANC_AW'(LOG) + ANC_AW'(lvl));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tlca_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on tlca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlca_front (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: new_node, parent_node, query_first, query_second.
  input  wire  [tlca_pkg::IN_DATA_W-1:0]     in_tdata,
  // Fields from bit 0: command.
  input  wire  [tlca_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                               q_valid,
  output tlca_pkg::op_t                      q_op,
  input  wire                                q_pop
);
  import tlca_pkg::*;

  op_t               queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  op_t               op_in;
  logic              keep;
  logic              push;
  logic              pop;

  // Classify the incoming transaction; inserts of the sentinel are dropped.
  always_comb begin
    op_in.is_query = (in_tuser[0] == CMD_QUERY);
    if (op_in.is_query) begin
      op_in.node_a = in_tdata[3*NODE_W-1:2*NODE_W];
      op_in.node_b = in_tdata[4*NODE_W-1:3*NODE_W];
    end else begin
      op_in.node_a = in_tdata[NODE_W-1:0];
      op_in.node_b = in_tdata[2*NODE_W-1:NODE_W];
    end
    keep = op_in.is_query || (op_in.node_a != '0);
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = q_pop && (count_r != '0);
  assign q_valid   = (count_r != '0);
  assign q_op      = queue_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlca_back.sv
// Back end: sequencer over the ancestor and depth memories, plus the result register.
// Depends on tlca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlca_back (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                q_valid,
  input  tlca_pkg::op_t                      q_op,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // Fields from bit 0: common_ancestor.
  output logic [tlca_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import tlca_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] S_INS_DEP = 5'd1;
  localparam logic [ST_W-1:0] S_INS_RD  = 5'd2;
  localparam logic [ST_W-1:0] S_INS_WR  = 5'd3;
  localparam logic [ST_W-1:0] S_Q_DA    = 5'd4;
  localparam logic [ST_W-1:0] S_Q_DB    = 5'd5;
  localparam logic [ST_W-1:0] S_Q_LIFT  = 5'd6;
  localparam logic [ST_W-1:0] S_Q_LIFTW = 5'd7;
  localparam logic [ST_W-1:0] S_Q_CMP   = 5'd8;
  localparam logic [ST_W-1:0] S_Q_TOPA  = 5'd9;
  localparam logic [ST_W-1:0] S_Q_TOPB  = 5'd10;
  localparam logic [ST_W-1:0] S_Q_TOPC  = 5'd11;
  localparam logic [ST_W-1:0] S_Q_FIN   = 5'd12;
  localparam logic [ST_W-1:0] S_Q_FINW  = 5'd13;
  localparam logic [ST_W-1:0] S_Q_OUT   = 5'd14;

  // Memories.
  node_t  anc_mem [ANC_ENTRIES];
  depth_t dep_mem [NODES];

  logic [ST_W-1:0] state_r, state_nxt;
  node_t           a_r, a_nxt;
  node_t           b_r, b_nxt;
  node_t           mid_r, mid_nxt;
  node_t           pa_r, pa_nxt;
  node_t           res_r, res_nxt;
  depth_t          da_r, da_nxt;
  logic [LOG-1:0]  gap_r, gap_nxt;
  lvl_t            lvl_r, lvl_nxt;
  logic            out_valid_r, out_valid_nxt;
  node_t           out_data_r, out_data_nxt;

  // Memory ports; read data is registered, node 0 reads as the sentinel.
  logic            anc_rd_en;
  anc_addr_t       anc_rd_addr;
  logic            anc_rd_zero;
  logic            anc_wr_en;
  anc_addr_t       anc_wr_addr;
  node_t           anc_wr_data;
  node_t           anc_q_r;
  logic            anc_zero_r;
  node_t           anc_val;

  logic            dep_rd_en;
  node_t           dep_rd_node;
  logic            dep_wr_en;
  node_t           dep_wr_node;
  depth_t          dep_wr_data;
  depth_t          dep_q_r;
  logic            dep_zero_r;
  depth_t          dep_val;

  assign anc_val = anc_zero_r ? '0 : anc_q_r;
  assign dep_val = dep_zero_r ? '0 : dep_q_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    mid_nxt       = mid_r;
    pa_nxt        = pa_r;
    res_nxt       = res_r;
    da_nxt        = da_r;
    gap_nxt       = gap_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    anc_rd_en     = 1'b0;
    anc_rd_addr   = '0;
    anc_rd_zero   = 1'b0;
    anc_wr_en     = 1'b0;
    anc_wr_addr   = '0;
    anc_wr_data   = '0;
    dep_rd_en     = 1'b0;
    dep_rd_node   = '0;
    dep_wr_en     = 1'b0;
    dep_wr_node   = '0;
    dep_wr_data   = '0;

    // The result register drains independently of the sequencer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          a_nxt     = q_op.node_a;
          b_nxt     = q_op.node_b;
          dep_rd_en = 1'b1;
          if (q_op.is_query) begin
            dep_rd_node = q_op.node_a;
            state_nxt   = S_Q_DA;
          end else begin
            // Level 0 is the parent itself; the parent's depth is fetched.
            dep_rd_node = q_op.node_b;
            anc_wr_en   = 1'b1;
            anc_wr_addr = anc_addr(q_op.node_a, '0);
            anc_wr_data = q_op.node_b;
            mid_nxt     = q_op.node_b;
            lvl_nxt     = lvl_t'(1);
            state_nxt   = S_INS_DEP;
          end
        end
      end
      S_INS_DEP: begin
        dep_wr_en   = 1'b1;
        dep_wr_node = a_r;
        dep_wr_data = (dep_val == DEPTH_MAX) ? DEPTH_MAX : depth_t'(dep_val + 1'b1);
        state_nxt   = S_INS_RD;
      end
      S_INS_RD: begin
        if (lvl_r == lvl_t'(LOG)) begin
          state_nxt = S_IDLE;
        end else begin
          anc_rd_en   = 1'b1;
          anc_rd_addr = anc_addr(mid_r, lvl_t'(lvl_r - 1'b1));
          anc_rd_zero = (mid_r == '0);
          state_nxt   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        anc_wr_en   = 1'b1;
        anc_wr_addr = anc_addr(a_r, lvl_r);
        anc_wr_data = anc_val;
        mid_nxt     = anc_val;
        lvl_nxt     = lvl_t'(lvl_r + 1'b1);
        state_nxt   = S_INS_RD;
      end
      S_Q_DA: begin
        da_nxt      = dep_val;
        dep_rd_en   = 1'b1;
        dep_rd_node = b_r;
        state_nxt   = S_Q_DB;
      end
      S_Q_DB: begin
        // Make a_r the deeper node; only the low LOG bits of the gap are lifted.
        if (da_r < dep_val) begin
          a_nxt   = b_r;
          b_nxt   = a_r;
          gap_nxt = LOG'(dep_val - da_r);
        end else begin
          gap_nxt = LOG'(da_r - dep_val);
        end
        lvl_nxt   = '0;
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        if (lvl_r == lvl_t'(LOG)) begin
          state_nxt = S_Q_CMP;
        end else if (gap_r[lvl_r]) begin
          anc_rd_en   = 1'b1;
          anc_rd_addr = anc_addr(a_r, lvl_r);
          anc_rd_zero = (a_r == '0);
          state_nxt   = S_Q_LIFTW;
        end else begin
          lvl_nxt = lvl_t'(lvl_r + 1'b1);
        end
      end
      S_Q_LIFTW: begin
        a_nxt     = anc_val;
        lvl_nxt   = lvl_t'(lvl_r + 1'b1);
        state_nxt = S_Q_LIFT;
      end
      S_Q_CMP: begin
        if (a_r == b_r) begin
          res_nxt   = a_r;
          state_nxt = S_Q_OUT;
        end else begin
          lvl_nxt   = lvl_t'(LOG - 1);
          state_nxt = S_Q_TOPA;
        end
      end
      S_Q_TOPA: begin
        anc_rd_en   = 1'b1;
        anc_rd_addr = anc_addr(a_r, lvl_r);
        anc_rd_zero = (a_r == '0);
        state_nxt   = S_Q_TOPB;
      end
      S_Q_TOPB: begin
        pa_nxt      = anc_val;
        anc_rd_en   = 1'b1;
        anc_rd_addr = anc_addr(b_r, lvl_r);
        anc_rd_zero = (b_r == '0);
        state_nxt   = S_Q_TOPC;
      end
      S_Q_TOPC: begin
        // Jump both nodes only while their ancestors at this level differ.
        if (pa_r != anc_val) begin
          a_nxt = pa_r;
          b_nxt = anc_val;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_FIN;
        end else begin
          lvl_nxt   = lvl_t'(lvl_r - 1'b1);
          state_nxt = S_Q_TOPA;
        end
      end
      S_Q_FIN: begin
        anc_rd_en   = 1'b1;
        anc_rd_addr = anc_addr(a_r, '0);
        anc_rd_zero = (a_r == '0);
        state_nxt   = S_Q_FINW;
      end
      S_Q_FINW: begin
        res_nxt   = anc_val;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    mid_r      <= mid_nxt;
    pa_r       <= pa_nxt;
    res_r      <= res_nxt;
    da_r       <= da_nxt;
    gap_r      <= gap_nxt;
    lvl_r      <= lvl_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ancestor memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (anc_wr_en) begin
      anc_mem[anc_wr_addr] <= anc_wr_data;
    end
    if (anc_rd_en) begin
      anc_q_r    <= anc_mem[anc_rd_addr];
      anc_zero_r <= anc_rd_zero;
    end
  end

  // Depth memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dep_wr_en) begin
      dep_mem[dep_wr_node[NODE_AW-1:0]] <= dep_wr_data;
    end
    if (dep_rd_en) begin
      dep_q_r    <= dep_mem[dep_rd_node[NODE_AW-1:0]];
      dep_zero_r <= (dep_rd_node == '0);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tree_lowest_common_ancestor_top.sv
// Top level of the lowest-common-ancestor block: front end, command queue, back end.
// Depends on tlca_pkg, tlca_front and tlca_back.
`timescale 1ns / 1ps
`default_nettype none

// Binary-lifting lowest common ancestor over a tree of up to 1024 nodes with
// 10 lifting levels. An insert transaction (in_tuser = 0) places new_node under
// parent_node, which must already be present; the root goes under node 0, the
// sentinel. A query transaction (in_tuser = 1) returns one result transaction
// holding the lowest common ancestor of query_first and query_second. Inserts
// produce no result. Work is set by the single read port of the ancestor memory,
// whose registered read makes each dependent lookup wait for its data. An insert
// fills the ancestor levels in turn; a query lifts the deeper node one lookup per
// set bit of the depth difference and, unless it then matches, steps both nodes
// down through every level and looks up the parent. A two-entry command queue and
// a result register let input acceptance and result delivery stall independently.
// No clearing pass is run after reset; node 0 always reads as the sentinel.
module tree_lowest_common_ancestor_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: new_node, parent_node, query_first, query_second.
  input  wire  [tlca_pkg::IN_DATA_W-1:0]   in_tdata,
  // Fields from bit 0: command.
  input  wire  [tlca_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // Fields from bit 0: common_ancestor.
  output logic [tlca_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tlca_pkg::*;

  logic q_valid;
  op_t  q_op;
  logic q_pop;

  // Accept and queue commands.
  tlca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop)
  );

  // Execute commands against the tables.
  tlca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
